/* hw/rtl/rtps_data_inline_qos_parser_macros.svh */
// Assertion macros shared by the inline QoS parser RTL.
`ifndef RTPS_DATA_INLINE_QOS_PARSER_MACROS_SVH
`define RTPS_DATA_INLINE_QOS_PARSER_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define RTPSDQ_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define RTPSDQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/rtpsdq_pkg.sv */
// Types, constants and helpers for the RTPS DATA inline QoS parser.
`timescale 1ns / 1ps

package rtpsdq_pkg;

    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] CFG_SENTINEL_PID    = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_STATUS_INFO_PID = 8'd1;

    localparam logic [15:0] SENTINEL_PID_RESET    = 16'd1;
    localparam logic [15:0] STATUS_INFO_PID_RESET = 16'd113;

    localparam logic [15:0] PARAM_HDR_BYTES    = 16'd4;
    localparam logic [15:0] STATUS_FLAG_POS    = 16'd3;
    localparam logic [7:0]  STATUS_REMOVE_MASK = 8'h03;

    typedef enum logic [2:0] {
        PH_HDR       = 3'd0,
        PH_PARAM_HDR = 3'd1,
        PH_SKIP      = 3'd2,
        PH_STATUS    = 3'd3,
        PH_PAYLOAD   = 3'd4
    } t_phase;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic        last_byte;
        logic        little_endian;
        logic        has_inline_qos;
        logic [31:0] guid_prefix_hi;
        logic [63:0] guid_prefix_lo;
    } t_item;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic        out_last;
        logic        out_drop;
        logic        remove_valid;
        logic [31:0] remove_guid_hi;
        logic [63:0] remove_guid_lo;
    } t_result;

    // Byte lane of the first octet of a 16-bit field.
    function automatic logic [15:0] first_half(input logic le, input logic [7:0] b);
        return le ? {8'h00, b} : {b, 8'h00};
    endfunction

    // Byte lane of the second octet of a 16-bit field.
    function automatic logic [15:0] second_half(input logic le, input logic [7:0] b);
        return le ? {b, 8'h00} : {8'h00, b};
    endfunction

endpackage

/* hw/rtl/rtpsdq_stream_if.sv */
// Valid/ready stream interface carrying one payload struct per transaction.
`timescale 1ns / 1ps

interface rtpsdq_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

/* hw/rtl/rtpsdq_out_reg.sv */
// Result register: holds one result transaction until the sink takes it.
`timescale 1ns / 1ps

module rtpsdq_out_reg (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_load,
    input  rtpsdq_pkg::t_result  i_result,
    output logic                 o_ready,
    rtpsdq_stream_if.source      o_out
);

    logic                r_valid;
    logic                n_valid;
    rtpsdq_pkg::t_result r_result;

    assign o_ready = !r_valid || o_out.ready;

    always_comb begin
        n_valid = r_valid;
        if (i_load) begin
            n_valid = 1'b1;
        end else if (o_out.ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_out.valid = r_valid;
    assign o_out.data  = r_result;

endmodule

/* hw/rtl/rtps_data_inline_qos_parser.sv */
// Top level of the RTPS DATA submessage inline QoS parser.
// Accepts one submessage body byte per clock and returns one result per byte,
// in the next cycle, from a result register; a new byte is taken in every cycle
// unless that register holds a result the sink has not yet taken. The header,
// octetsToInlineQos gap and parameter list are tracked by a small phase/offset
// state updated in the same cycle a byte is accepted. Bytes of the header past
// HEADER_SIZE and all inline QoS bytes are flagged for drop; a StatusInfo
// value with the disposed or unregistered bit set raises a remove event with
// the source GUID prefix. A byte with the last mark returns the parser to the
// header phase. Configuration writes are taken at any time; there is no
// clearing pass after reset.
`timescale 1ns / 1ps
`include "rtps_data_inline_qos_parser_macros.svh"

module rtps_data_inline_qos_parser #(
    parameter int HEADER_SIZE          = 20,
    parameter int QOS_OFFSET_FIELD_POS = 2
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic [rtpsdq_pkg::CFG_INDEX_W-1:0]    i_cfg_index,
    input  logic [rtpsdq_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    rtpsdq_stream_if.sink                         i_in,
    rtpsdq_stream_if.source                       o_out
);

    localparam logic [15:0] QOS_POS     = 16'(QOS_OFFSET_FIELD_POS);
    localparam logic [15:0] QOS_POS_1   = 16'(QOS_OFFSET_FIELD_POS + 1);
    localparam logic [16:0] GAP_BASE    = 17'(QOS_OFFSET_FIELD_POS + 2);
    localparam logic [15:0] HDR_SIZE_16 = 16'(HEADER_SIZE);

    logic [15:0]        r_sentinel_pid;
    logic [15:0]        r_status_info_pid;

    rtpsdq_pkg::t_phase r_phase;
    rtpsdq_pkg::t_phase n_phase;
    logic [15:0]        r_offset;
    logic [15:0]        n_offset;
    logic [15:0]        r_cur_pid;
    logic [15:0]        n_cur_pid;
    logic [15:0]        r_field_len;
    logic [15:0]        n_field_len;

    logic [15:0]        offset_inc;
    logic [16:0]        gap_end;
    logic               drop;
    logic               remove;
    logic               accept;
    logic               out_ready;
    rtpsdq_pkg::t_item   item;
    rtpsdq_pkg::t_result result;

    assign item   = i_in.data;
    assign accept = i_in.valid && out_ready;
    assign i_in.ready = out_ready;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sentinel_pid    <= rtpsdq_pkg::SENTINEL_PID_RESET;
            r_status_info_pid <= rtpsdq_pkg::STATUS_INFO_PID_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                rtpsdq_pkg::CFG_SENTINEL_PID: begin
                    r_sentinel_pid <= i_cfg_data;
                end
                rtpsdq_pkg::CFG_STATUS_INFO_PID: begin
                    r_status_info_pid <= i_cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    // Parse step for the byte at the input
    always_comb begin
        n_phase     = r_phase;
        n_offset    = r_offset;
        n_cur_pid   = r_cur_pid;
        n_field_len = r_field_len;
        offset_inc  = r_offset + 16'd1;
        gap_end     = '0;
        drop        = 1'b1;
        remove      = 1'b0;

        case (r_phase)
            rtpsdq_pkg::PH_HDR: begin
                if (r_offset == QOS_POS) begin
                    n_field_len = rtpsdq_pkg::first_half(item.little_endian, item.data_byte);
                end else if (r_offset == QOS_POS_1) begin
                    n_field_len = r_field_len |
                        rtpsdq_pkg::second_half(item.little_endian, item.data_byte);
                end
                drop     = r_offset >= HDR_SIZE_16;
                n_offset = offset_inc;
                gap_end  = GAP_BASE + {1'b0, n_field_len};
                if (({1'b0, offset_inc} >= GAP_BASE) && ({1'b0, offset_inc} == gap_end)) begin
                    n_offset = '0;
                    n_phase  = item.has_inline_qos ? rtpsdq_pkg::PH_PARAM_HDR
                                                   : rtpsdq_pkg::PH_PAYLOAD;
                end
            end
            rtpsdq_pkg::PH_PARAM_HDR: begin
                case (r_offset)
                    16'd0: begin
                        n_cur_pid = rtpsdq_pkg::first_half(item.little_endian, item.data_byte);
                    end
                    16'd1: begin
                        n_cur_pid = r_cur_pid |
                            rtpsdq_pkg::second_half(item.little_endian, item.data_byte);
                    end
                    16'd2: begin
                        n_field_len = rtpsdq_pkg::first_half(item.little_endian, item.data_byte);
                    end
                    16'd3: begin
                        n_field_len = r_field_len |
                            rtpsdq_pkg::second_half(item.little_endian, item.data_byte);
                    end
                    default: begin
                    end
                endcase
                n_offset = offset_inc;
                if (offset_inc == rtpsdq_pkg::PARAM_HDR_BYTES) begin
                    n_offset = '0;
                    if (n_field_len == 16'd0) begin
                        n_phase = (n_cur_pid == r_sentinel_pid) ? rtpsdq_pkg::PH_PAYLOAD
                                                                : rtpsdq_pkg::PH_PARAM_HDR;
                    end else if (n_cur_pid == r_status_info_pid) begin
                        n_phase = rtpsdq_pkg::PH_STATUS;
                    end else begin
                        n_phase = rtpsdq_pkg::PH_SKIP;
                    end
                end
            end
            rtpsdq_pkg::PH_SKIP: begin
                n_offset = offset_inc;
                if (offset_inc == r_field_len) begin
                    n_offset = '0;
                    n_phase  = (r_cur_pid == r_sentinel_pid) ? rtpsdq_pkg::PH_PAYLOAD
                                                             : rtpsdq_pkg::PH_PARAM_HDR;
                end
            end
            rtpsdq_pkg::PH_STATUS: begin
                remove = (r_offset == rtpsdq_pkg::STATUS_FLAG_POS) &&
                         ((item.data_byte & rtpsdq_pkg::STATUS_REMOVE_MASK) != 8'h00);
                n_offset = offset_inc;
                if (offset_inc == r_field_len) begin
                    n_offset = '0;
                    n_phase  = rtpsdq_pkg::PH_PARAM_HDR;
                end
            end
            default: begin
                drop = 1'b0;
            end
        endcase

        if (item.last_byte) begin
            n_offset = '0;
            n_phase  = rtpsdq_pkg::PH_HDR;
        end

        result.out_byte       = item.data_byte;
        result.out_last       = item.last_byte;
        result.out_drop       = drop;
        result.remove_valid   = remove;
        result.remove_guid_hi = remove ? item.guid_prefix_hi : 32'h0;
        result.remove_guid_lo = remove ? item.guid_prefix_lo : 64'h0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= rtpsdq_pkg::PH_HDR;
            r_offset    <= '0;
            r_cur_pid   <= '0;
            r_field_len <= '0;
        end else if (accept) begin
            r_phase     <= n_phase;
            r_offset    <= n_offset;
            r_cur_pid   <= n_cur_pid;
            r_field_len <= n_field_len;
        end
    end

    rtpsdq_out_reg u_out_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (accept),
        .i_result (result),
        .o_ready  (out_ready),
        .o_out    (o_out)
    );

    `RTPSDQ_ASSERT_NEXT(a_last_resets, i_clk, i_rst_n,
        accept && item.last_byte,
        (r_phase == rtpsdq_pkg::PH_HDR) && (r_offset == 16'd0),
        "last byte did not return parser to header phase")
    `RTPSDQ_ASSERT_NOW(a_no_overwrite, i_clk, i_rst_n,
        o_out.valid && !o_out.ready, !i_in.ready,
        "input taken while result register is stalled")
    `RTPSDQ_ASSERT_NOW(a_guid_zero, i_clk, i_rst_n,
        o_out.valid && !o_out.data.remove_valid,
        (o_out.data.remove_guid_hi == 32'h0) && (o_out.data.remove_guid_lo == 64'h0),
        "GUID prefix present without remove event")
    `RTPSDQ_ASSERT_NOW(a_remove_dropped, i_clk, i_rst_n,
        o_out.valid && o_out.data.remove_valid, o_out.data.out_drop,
        "remove event on a byte not marked for drop")
    `RTPSDQ_ASSERT_NEXT(a_state_holds, i_clk, i_rst_n,
        !accept, $stable(r_phase) && $stable(r_offset),
        "parser state changed without an input transaction")

endmodule

/* tb/rtps_data_inline_qos_parser_checker.sv */
`timescale 1ns / 1ps
// Scoreboard for the inline QoS parser: predicts each result transaction and compares it.
module rtps_data_inline_qos_parser_checker
    import rtpsdq_pkg::*;
#(
    parameter int HEADER_SIZE          = 20,
    parameter int QOS_OFFSET_FIELD_POS = 2
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                   i_in_valid,
    input  logic                   i_in_ready,
    input  t_item                  i_in_data,
    input  logic                   i_out_valid,
    input  logic                   i_out_ready,
    input  t_result                i_out_data,
    output int                     o_mismatches,
    output int                     o_outstanding
);

    localparam logic [15:0] GAP_LO_POS   = 16'(QOS_OFFSET_FIELD_POS);
    localparam logic [15:0] GAP_HI_POS   = 16'(QOS_OFFSET_FIELD_POS + 1);
    localparam logic [15:0] HDR_KEEP     = 16'(HEADER_SIZE);
    localparam logic [16:0] GAP_MIN_END  = 17'(QOS_OFFSET_FIELD_POS + 2);
    localparam int          REPORT_LIMIT = 10;

    t_phase      phase       = PH_HDR;
    logic [15:0] offset      = '0;
    logic [15:0] cur_pid     = '0;
    logic [15:0] field_len   = '0;
    logic [15:0] sentinel_id = SENTINEL_PID_RESET;
    logic [15:0] status_id   = STATUS_INFO_PID_RESET;
    t_result     parsed_q[$];
    int          mismatches  = 0;

    function automatic t_result parse_byte(input t_item it);
        t_result     r;
        logic [15:0] lane0;
        logic [15:0] lane1;
        logic [16:0] gap_end;
        r            = '0;
        r.out_byte   = it.data_byte;
        r.out_last   = it.last_byte;
        r.out_drop   = 1'b1;
        lane0 = it.little_endian ? {8'h00, it.data_byte} : {it.data_byte, 8'h00};
        lane1 = it.little_endian ? {it.data_byte, 8'h00} : {8'h00, it.data_byte};
        case (phase)
            PH_HDR: begin
                if (offset == GAP_LO_POS) begin
                    field_len = lane0;
                end else if (offset == GAP_HI_POS) begin
                    field_len = field_len | lane1;
                end
                r.out_drop = (offset >= HDR_KEEP);
                offset     = offset + 16'd1;
                // no wrap on the gap end: a gap near 64K keeps the header open
                gap_end = GAP_MIN_END + {1'b0, field_len};
                if ({1'b0, offset} >= GAP_MIN_END && {1'b0, offset} == gap_end) begin
                    offset = '0;
                    if (it.has_inline_qos) begin
                        phase = PH_PARAM_HDR;
                    end else begin
                        phase = PH_PAYLOAD;
                    end
                end
            end
            PH_PARAM_HDR: begin
                case (offset)
                    16'd0: cur_pid = lane0;
                    16'd1: cur_pid = cur_pid | lane1;
                    16'd2: field_len = lane0;
                    16'd3: field_len = field_len | lane1;
                    default: ;
                endcase
                offset = offset + 16'd1;
                if (offset == PARAM_HDR_BYTES) begin
                    offset = '0;
                    if (field_len == '0) begin
                        if (cur_pid == sentinel_id) begin
                            phase = PH_PAYLOAD;
                        end else begin
                            phase = PH_PARAM_HDR;
                        end
                    end else if (cur_pid == status_id) begin
                        phase = PH_STATUS;
                    end else begin
                        phase = PH_SKIP;
                    end
                end
            end
            PH_SKIP: begin
                offset = offset + 16'd1;
                if (offset == field_len) begin
                    offset = '0;
                    if (cur_pid == sentinel_id) begin
                        phase = PH_PAYLOAD;
                    end else begin
                        phase = PH_PARAM_HDR;
                    end
                end
            end
            PH_STATUS: begin
                if (offset == STATUS_FLAG_POS && (it.data_byte & STATUS_REMOVE_MASK) != '0) begin
                    r.remove_valid   = 1'b1;
                    r.remove_guid_hi = it.guid_prefix_hi;
                    r.remove_guid_lo = it.guid_prefix_lo;
                end
                offset = offset + 16'd1;
                if (offset == field_len) begin
                    offset = '0;
                    phase  = PH_PARAM_HDR;
                end
            end
            default: r.out_drop = 1'b0;
        endcase
        if (it.last_byte) begin
            offset = '0;
            phase  = PH_HDR;
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_result want;
        logic    bad;
        if (!i_rst_n) begin
            phase       = PH_HDR;
            offset      = '0;
            cur_pid     = '0;
            field_len   = '0;
            sentinel_id = SENTINEL_PID_RESET;
            status_id   = STATUS_INFO_PID_RESET;
            parsed_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_SENTINEL_PID:    sentinel_id = i_cfg_data;
                    CFG_STATUS_INFO_PID: status_id   = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_out_valid && i_out_ready) begin
                if (parsed_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT) begin
                        $display("%0t: result transaction with nothing pending, byte %h",
                                 $time, i_out_data.out_byte);
                    end
                end else begin
                    want = parsed_q.pop_front();
                    bad  = (i_out_data.out_byte !== want.out_byte) ||
                           (i_out_data.out_last !== want.out_last) ||
                           (i_out_data.out_drop !== want.out_drop) ||
                           (i_out_data.remove_valid !== want.remove_valid) ||
                           (i_out_data.remove_guid_hi !== want.remove_guid_hi) ||
                           (i_out_data.remove_guid_lo !== want.remove_guid_lo);
                    if (bad) begin
                        mismatches++;
                        if (mismatches <= REPORT_LIMIT) begin
                            $display("%0t: exp byte %h last %b drop %b rm %b guid %h_%h",
                                     $time, want.out_byte, want.out_last, want.out_drop,
                                     want.remove_valid, want.remove_guid_hi,
                                     want.remove_guid_lo);
                            $display("%0t: got byte %h last %b drop %b rm %b guid %h_%h",
                                     $time, i_out_data.out_byte, i_out_data.out_last,
                                     i_out_data.out_drop, i_out_data.remove_valid,
                                     i_out_data.remove_guid_hi, i_out_data.remove_guid_lo);
                        end
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                parsed_q.push_back(parse_byte(i_in_data));
            end
        end
        o_mismatches  = mismatches;
        o_outstanding = parsed_q.size();
    end

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps
// Top of the inline QoS parser testbench: clock, reset, stimulus, receiver and verdict.
module tb;
    import rtpsdq_pkg::*;

    localparam int HDR_BYTES    = 20;
    localparam int QOS_POS      = 2;
    localparam int RANDOM_ITEMS = 1350;
    localparam int PHASES       = 5;
    localparam int HOLD_CYCLES  = 300;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int SETTLE       = 4;

    typedef enum {RX_OPEN, RX_HALF, RX_SPARSE, RX_BUSY} t_rx_mode;

    logic                   i_clk       = 1'b0;
    logic                   i_rst_n     = 1'b0;
    logic                   i_cfg_we    = 1'b0;
    logic [CFG_INDEX_W-1:0] i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data  = '0;
    logic                   in_taken    = 1'b0;
    bit                     hold_req    = 1'b0;
    int                     cycles      = 0;
    int                     n_items     = 0;
    int                     burst_left  = 0;
    int                     mismatches;
    int                     outstanding;
    logic [15:0]            cur_sentinel = SENTINEL_PID_RESET;
    logic [15:0]            cur_status   = STATUS_INFO_PID_RESET;

    rtpsdq_stream_if #(.T(t_item))   in_if ();
    rtpsdq_stream_if #(.T(t_result)) out_if ();

    rtps_data_inline_qos_parser #(
        .HEADER_SIZE(HDR_BYTES),
        .QOS_OFFSET_FIELD_POS(QOS_POS)
    ) uut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data(i_cfg_data),
        .i_in(in_if),
        .o_out(out_if)
    );

    rtps_data_inline_qos_parser_checker #(
        .HEADER_SIZE(HDR_BYTES),
        .QOS_OFFSET_FIELD_POS(QOS_POS)
    ) chk (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data(i_cfg_data),
        .i_in_valid(in_if.valid),
        .i_in_ready(in_if.ready),
        .i_in_data(in_if.data),
        .i_out_valid(out_if.valid),
        .i_out_ready(out_if.ready),
        .i_out_data(out_if.data),
        .o_mismatches(mismatches),
        .o_outstanding(outstanding)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        in_taken <= in_if.valid && in_if.ready;
        cycles   <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("rtps_data_inline_qos_parser test failed");
            $finish;
        end
    end

    // result sink: random stall modes, plus one long hold-off on request
    initial begin
        t_rx_mode mode;
        int       mode_left;
        int       hold_left;
        out_if.ready = 1'b0;
        mode         = RX_OPEN;
        mode_left    = 0;
        hold_left    = 0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                out_if.ready <= 1'b0;
                hold_left--;
            end else if (hold_req) begin
                hold_req     = 1'b0;
                hold_left    = HOLD_CYCLES;
                out_if.ready <= 1'b0;
            end else begin
                if (mode_left == 0) begin
                    mode      = t_rx_mode'($urandom_range(0, 3));
                    mode_left = $urandom_range(10, 80);
                end
                mode_left--;
                case (mode)
                    RX_OPEN:   out_if.ready <= 1'b1;
                    RX_HALF:   out_if.ready <= ($urandom_range(0, 1) == 0);
                    RX_SPARSE: out_if.ready <= ($urandom_range(0, 3) == 0);
                    default:   out_if.ready <= ($urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

    function automatic void append_u16(ref logic [7:0] q[$], input bit le,
                                       input logic [15:0] v);
        if (le) begin
            q.push_back(v[7:0]);
            q.push_back(v[15:8]);
        end else begin
            q.push_back(v[15:8]);
            q.push_back(v[7:0]);
        end
    endfunction

    task automatic offer(input t_item it);
        if (burst_left == 0) begin
            if ($urandom_range(0, 3) != 0) begin
                in_if.valid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(negedge i_clk);
            end
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 160)
                                                     : $urandom_range(1, 12);
        end
        burst_left--;
        in_if.valid <= 1'b1;
        in_if.data  <= it;
        do @(negedge i_clk); while (!in_taken);
        n_items++;
    endtask

    task automatic send_body(input logic [7:0] body[$], input bit le, input bit qos,
                             input logic [31:0] ghi, input logic [63:0] glo);
        t_item it;
        for (int i = 0; i < body.size(); i++) begin
            it.data_byte      = body[i];
            it.last_byte      = (i == body.size() - 1);
            it.little_endian  = le;
            it.has_inline_qos = qos;
            it.guid_prefix_hi = ghi;
            it.guid_prefix_lo = glo;
            offer(it);
        end
    endtask

    task automatic send_submsg(input bit le, input bit qos, input logic [15:0] gap,
                               input bit cut);
        logic [7:0]  body[$];
        logic [15:0] pid;
        logic [15:0] plen;
        int          n_gap;
        int          n_keep;
        body.push_back(8'($urandom));
        body.push_back(8'($urandom));
        append_u16(body, le, gap);
        n_gap = (gap > 16'd40) ? 40 : int'(gap);
        repeat (n_gap) body.push_back(8'($urandom));
        if (qos) begin
            repeat ($urandom_range(0, 4)) begin
                if ($urandom_range(0, 1) == 0) begin
                    pid  = cur_status;
                    plen = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 7)) : 16'd4;
                end else begin
                    do pid = 16'($urandom); while (pid == cur_status || pid == cur_sentinel);
                    plen = 16'($urandom_range(0, 12));
                end
                append_u16(body, le, pid);
                append_u16(body, le, plen);
                repeat (int'(plen)) body.push_back(8'($urandom));
            end
            plen = ($urandom_range(0, 4) == 0) ? 16'($urandom_range(1, 8)) : 16'd0;
            append_u16(body, le, cur_sentinel);
            append_u16(body, le, plen);
            repeat (int'(plen)) body.push_back(8'($urandom));
        end
        repeat ($urandom_range(0, 16)) body.push_back(8'($urandom));
        if (cut) begin
            n_keep = $urandom_range(1, body.size());
            while (body.size() > n_keep) void'(body.pop_back());
        end
        send_body(body, le, qos, 32'($urandom), {32'($urandom), 32'($urandom)});
    endtask

    task automatic send_noise(input int n);
        t_item it;
        for (int i = 0; i < n; i++) begin
            it.data_byte      = 8'($urandom);
            it.last_byte      = (i == n - 1) || ($urandom_range(0, 7) == 0);
            it.little_endian  = 1'($urandom);
            it.has_inline_qos = 1'($urandom);
            it.guid_prefix_hi = 32'($urandom);
            it.guid_prefix_lo = {32'($urandom), 32'($urandom)};
            offer(it);
        end
    endtask

    task automatic drain();
        in_if.valid <= 1'b0;
        burst_left  = 0;
        do @(negedge i_clk); while (outstanding != 0);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task automatic set_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // also hits an unused index, which must leave both ids alone
    task automatic program_ids(input logic [15:0] sentinel, input logic [15:0] status);
        set_reg(CFG_SENTINEL_PID, sentinel);
        set_reg(CFG_STATUS_INFO_PID, status);
        set_reg(CFG_INDEX_W'($urandom_range(int'(CFG_STATUS_INFO_PID) + 1,
                                            (1 << CFG_INDEX_W) - 1)),
                16'($urandom));
        cur_sentinel = sentinel;
        cur_status   = status;
    endtask

    initial begin
        logic [7:0]  body[$];
        logic [15:0] gap;
        logic [15:0] shared_id;
        int          pick;
        int          phase_end;
        bit          le;
        bit          qos;
        in_if.valid = 1'b0;
        in_if.data  = '0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // big endian, zero gap, disposed status, empty sentinel, payload
        body.push_back(8'hff);
        body.push_back(8'h00);
        append_u16(body, 1'b0, 16'd0);
        append_u16(body, 1'b0, STATUS_INFO_PID_RESET);
        append_u16(body, 1'b0, 16'd4);
        body.push_back(8'h00);
        body.push_back(8'h00);
        body.push_back(8'h00);
        body.push_back(8'h01);
        append_u16(body, 1'b0, SENTINEL_PID_RESET);
        append_u16(body, 1'b0, 16'd0);
        body.push_back(8'hff);
        body.push_back(8'h00);
        send_body(body, 1'b0, 1'b1, '1, '1);

        // little endian gap that overflows: header never closes before the end mark
        body.delete();
        body.push_back(8'h00);
        body.push_back(8'h80);
        append_u16(body, 1'b1, 16'hffff);
        body.push_back(8'h55);
        body.push_back(8'haa);
        send_body(body, 1'b1, 1'b0, '0, '0);

        for (int p = 0; p < PHASES; p++) begin
            if (p != 0) begin
                drain();
                case (p)
                    1: program_ids(16'h0000, 16'hffff);
                    2: program_ids(16'hffff, 16'h0000);
                    3: begin
                        shared_id = 16'($urandom);
                        program_ids(shared_id, shared_id);
                    end
                    default: program_ids(16'($urandom), 16'($urandom));
                endcase
            end
            if (p == 1) begin
                hold_req = 1'b1;
            end
            phase_end = n_items + RANDOM_ITEMS / PHASES;
            while (n_items < phase_end) begin
                pick = $urandom_range(0, 19);
                le   = 1'($urandom);
                qos  = ($urandom_range(0, 4) != 0);
                case ($urandom_range(0, 19))
                    19:      gap = 16'($urandom_range(65532, 65535));
                    12, 13, 14, 15, 16, 17, 18:
                             gap = 16'($urandom_range(0, 28));
                    default: gap = 16'd16;
                endcase
                if (pick < 16) begin
                    send_submsg(le, qos, gap, 1'b0);
                end else if (pick < 18) begin
                    send_submsg(le, qos, gap, 1'b1);
                end else begin
                    send_noise($urandom_range(3, 20));
                end
            end
        end

        drain();
        if (mismatches == 0 && outstanding == 0) begin
            $display("rtps_data_inline_qos_parser test passed");
        end else begin
            $display("rtps_data_inline_qos_parser test failed");
        end
        $finish;
    end

endmodule

/* filelist.f */
+incdir+hw/rtl
hw/rtl/rtpsdq_pkg.sv
hw/rtl/rtpsdq_stream_if.sv
hw/rtl/rtpsdq_out_reg.sv
hw/rtl/rtps_data_inline_qos_parser.sv
tb/rtps_data_inline_qos_parser_checker.sv
tb/tb.sv
